>>> rtl/life_grid_generation_step_unit_macros.svh
// assertion macros used by the checker file
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define LGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LGS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

  // grid size
  localparam int unsigned GRID_ROWS = 32;
  localparam int unsigned GRID_COLS = 64;

  // payload widths fixed by the item format
  localparam int unsigned ROW_W = 5;
  localparam int unsigned COL_W = 6;
  localparam int unsigned REQ_W = 2;

  // neighbor count of eight bits fits in four
  localparam int unsigned CNT_W = 4;

  // rule B3/S23
  localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_CNT = CNT_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_type_e;

  // command broadcast to every row cell
  typedef struct packed {
    logic                 step;
    logic                 wr;
    logic                 val;
    logic [GRID_COLS-1:0] col_mask;
  } cell_cmd_t;

endpackage

>>> rtl/lgs_if.sv
`timescale 1ns / 1ps

// request channel
interface lgs_req_if;
  logic                         valid;
  logic                         ready;
  logic [lgs_pkg::REQ_W-1:0]    req_type;
  logic [lgs_pkg::ROW_W-1:0]    row;
  logic [lgs_pkg::COL_W-1:0]    col;
  logic                         cell_in;

  modport source (output valid, req_type, row, col, cell_in, input ready);
  modport sink   (input valid, req_type, row, col, cell_in, output ready);
endinterface

// response channel
interface lgs_rsp_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic step_done;

  modport source (output valid, cell_out, step_done, input ready);
  modport sink   (input valid, cell_out, step_done, output ready);
endinterface

>>> rtl/life_grid_generation_step_unit.sv
`timescale 1ns / 1ps

// life grid generation step unit, rule B3/S23 on a GRID_ROWS x GRID_COLS grid
// req_i carries one item: write a cell, read a cell, or advance one generation
// rsp_o returns exactly one item per request: cell_out for a read, step_done
// for a generation step, both zero for a write or an unused request code
// the grid is a chain of row cells, each with its own neighbor counters per
// column, so a full generation updates every row cell at once
// the response is registered and valid on the cycle after the request is accepted
// throughput: one item per cycle while the response side keeps taking items
// the response sits in an output register; req_i.ready stays high while that
// register is empty or being drained, and drops only while it is full and
// rsp_o.ready is low, so nothing is lost when the receiver stalls
// reset clears every cell to dead and empties the output register
// border rows and columns hold their values through a step but can be
// written and read; cells outside the grid ignore writes and read as zero
module life_grid_generation_step_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  lgs_req_if.sink   req_i,
  lgs_rsp_if.source rsp_o
);

  localparam int unsigned ROWS = lgs_pkg::GRID_ROWS;
  localparam int unsigned COLS = lgs_pkg::GRID_COLS;

  // handshake and output register
  logic rsp_valid_q, rsp_valid_d;
  logic cell_out_q, cell_out_d;
  logic step_done_q, step_done_d;
  logic req_accept;

  // chain of row cells
  logic [COLS-1:0]    rows [ROWS];
  logic [ROWS-1:0]    row_sel;
  logic [ROWS-1:0]    rd_bits;
  lgs_pkg::cell_cmd_t cmd;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;

  // one-hot column mask, empty for a column past the grid
  always_comb begin
    cmd.col_mask = '0;
    for (int c = 0; c < int'(COLS); c++) begin
      cmd.col_mask[c] = (32'(req_i.col) == 32'(c));
    end
    cmd.step = req_accept && (req_i.req_type == lgs_pkg::REQ_STEP);
    cmd.wr   = req_accept && (req_i.req_type == lgs_pkg::REQ_WRITE);
    cmd.val  = req_i.cell_in;
  end

  for (genvar r = 0; r < int'(ROWS); r++) begin : g_row
    logic [COLS-1:0] above, below;

    // rows past the grid edge feed zeros, only border rows see them
    if (r == 0) begin : g_top
      assign above = '0;
    end else begin : g_mid_a
      assign above = rows[r-1];
    end
    if (r == int'(ROWS) - 1) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = rows[r+1];
    end

    // row decode, no cell matches a row past the grid
    assign row_sel[r] = (32'(req_i.row) == 32'(r));

    lgs_row_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .row_sel_i (row_sel[r]),
      .border_i  ((r == 0) || (r == int'(ROWS) - 1)),
      .above_i   (above),
      .below_i   (below),
      .row_o     (rows[r]),
      .rd_bit_o  (rd_bits[r])
    );
  end

  // response register loads on accept, clears when drained
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    cell_out_d  = cell_out_q;
    step_done_d = step_done_q;
    if (req_accept) begin
      rsp_valid_d = 1'b1;
      cell_out_d  = (req_i.req_type == lgs_pkg::REQ_READ) && |rd_bits;
      step_done_d = (req_i.req_type == lgs_pkg::REQ_STEP);
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_out_q  <= cell_out_d;
    step_done_q <= step_done_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.cell_out  = cell_out_q;
  assign rsp_o.step_done = step_done_q;

endmodule

>>> rtl/lgs_row_cell.sv
`timescale 1ns / 1ps

// one grid row: holds its word, takes the neighbor rows from the chain
module lgs_row_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lgs_pkg::cell_cmd_t                 cmd_i,
  input  logic                               row_sel_i,
  input  logic                               border_i,
  input  logic [lgs_pkg::GRID_COLS-1:0]      above_i,
  input  logic [lgs_pkg::GRID_COLS-1:0]      below_i,
  output logic [lgs_pkg::GRID_COLS-1:0]      row_o,
  output logic                               rd_bit_o
);

  logic [lgs_pkg::GRID_COLS-1:0] row_q, row_d;
  logic [lgs_pkg::GRID_COLS-1:0] next_row;

  // per-column rule, interior columns only
  always_comb begin
    logic [lgs_pkg::CNT_W-1:0] n;
    next_row = row_q;
    for (int c = 1; c < int'(lgs_pkg::GRID_COLS) - 1; c++) begin
      n = lgs_pkg::CNT_W'(above_i[c-1]) + lgs_pkg::CNT_W'(above_i[c])
        + lgs_pkg::CNT_W'(above_i[c+1]) + lgs_pkg::CNT_W'(row_q[c-1])
        + lgs_pkg::CNT_W'(row_q[c+1])   + lgs_pkg::CNT_W'(below_i[c-1])
        + lgs_pkg::CNT_W'(below_i[c])   + lgs_pkg::CNT_W'(below_i[c+1]);
      next_row[c] = (n == lgs_pkg::BIRTH_CNT) || (row_q[c] && (n == lgs_pkg::SURVIVE_CNT));
    end
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.step) begin
      if (!border_i) begin
        row_d = next_row;
      end
    end else if (cmd_i.wr && row_sel_i) begin
      row_d = cmd_i.val ? (row_q | cmd_i.col_mask) : (row_q & ~cmd_i.col_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o    = row_q;
  assign rd_bit_o = row_sel_i && |(row_q & cmd_i.col_mask);

endmodule

>>> rtl/lgs_checker.sv
`timescale 1ns / 1ps
`include "life_grid_generation_step_unit_macros.svh"

module lgs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic [lgs_pkg::REQ_W-1:0]     req_type_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          cell_out_i,
  input logic                          step_done_i
);

  `LGS_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped while stalled")
  `LGS_ASSERT(a_accept_rsp, req_valid_i && req_ready_i |=> rsp_valid_i, "accepted item gave no response")
  `LGS_ASSERT(a_step_done, req_valid_i && req_ready_i && req_type_i == lgs_pkg::REQ_STEP |=> step_done_i && !cell_out_i, "step item lacks step_done")
  `LGS_ASSERT(a_no_overrun, rsp_valid_i && !rsp_ready_i |-> !req_ready_i, "request taken over a full output")
  `LGS_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !rsp_valid_i, "response valid out of reset")

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .cell_out_i  (rsp_o.cell_out),
  .step_done_i (rsp_o.step_done)
);
